// ===== rtl/core/ccsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ccsp_pkg;

    // string grammar limits
    localparam int NAME_COUNT        = 19;
    localparam int NAME_MAX_LEN      = 11;
    localparam int NAME_IDX_W        = $clog2(NAME_COUNT);
    localparam int ALPHA_FRAC_DIGITS = 3;
    localparam logic [3:0] HEX_LEN   = 4'd7;

    // alpha scaling: round(f * 255 / 1000) = floor((f * 51 + 100) / 200)
    // the divide by 200 is a shift by 3 then a reciprocal multiply for 25
    localparam int ALPHA_SCALE       = 51;
    localparam int ALPHA_BIAS        = 100;
    localparam int ALPHA_PRE_SHIFT   = 3;
    localparam int ALPHA_RECIP       = 5243;
    localparam int ALPHA_RECIP_SHIFT = 17;

    // character codes
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LG     = 8'h67;
    localparam logic [7:0] CH_LR     = 8'h72;

    // result form codes
    localparam logic [2:0] FORM_NAMED   = 3'd0;
    localparam logic [2:0] FORM_HEX     = 3'd1;
    localparam logic [2:0] FORM_RGB     = 3'd2;
    localparam logic [2:0] FORM_UNKNOWN = 3'd3;
    localparam logic [2:0] FORM_BAD_HEX = 3'd4;

    // positions in the rgb grammar
    localparam logic [3:0] STG_AFTER_R    = 4'd0;
    localparam logic [3:0] STG_AFTER_G    = 4'd1;
    localparam logic [3:0] STG_AFTER_B    = 4'd2;
    localparam logic [3:0] STG_RED        = 4'd3;
    localparam logic [3:0] STG_LAST_COMP  = 4'd11;
    localparam logic [3:0] STG_ALPHA_OPEN = 4'd12;
    localparam logic [3:0] STG_ALPHA_INT  = 4'd13;
    localparam logic [3:0] STG_ALPHA_FRAC = 4'd14;
    localparam logic [3:0] STG_ALPHA_DONE = 4'd15;

    typedef enum logic [2:0] {
        MODE_START,
        MODE_HEX,
        MODE_RGB,
        MODE_CLOSED,
        MODE_NONE,
        MODE_ATRAIL
    } t_mode;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [2:0] form;
    } t_out;

    // parse result before alpha scaling
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [2:0] form;
        logic       alpha_calc;
        logic [9:0] alpha_frac;
    } t_res;

    typedef struct packed {
        logic [8*NAME_MAX_LEN-1:0] text;
        logic [3:0]                len;
        logic [7:0]                red;
        logic [7:0]                green;
        logic [7:0]                blue;
        logic [7:0]                alpha;
    } t_name;

    // named color table, text left aligned and padded with spaces
    function automatic t_name name_entry(input logic [NAME_IDX_W-1:0] idx);
        t_name e;
        case (idx)
            5'd0:    e = '{"transparent", 4'd11, 8'd255, 8'd255, 8'd255, 8'd0};
            5'd1:    e = '{"black      ", 4'd5,  8'd0,   8'd0,   8'd0,   8'd255};
            5'd2:    e = '{"silver     ", 4'd6,  8'd192, 8'd192, 8'd192, 8'd255};
            5'd3:    e = '{"gray       ", 4'd4,  8'd128, 8'd128, 8'd128, 8'd255};
            5'd4:    e = '{"grey       ", 4'd4,  8'd128, 8'd128, 8'd128, 8'd255};
            5'd5:    e = '{"white      ", 4'd5,  8'd255, 8'd255, 8'd255, 8'd255};
            5'd6:    e = '{"maroon     ", 4'd6,  8'd128, 8'd0,   8'd0,   8'd255};
            5'd7:    e = '{"red        ", 4'd3,  8'd255, 8'd0,   8'd0,   8'd255};
            5'd8:    e = '{"purple     ", 4'd6,  8'd128, 8'd0,   8'd128, 8'd255};
            5'd9:    e = '{"fuchsia    ", 4'd7,  8'd255, 8'd0,   8'd255, 8'd255};
            5'd10:   e = '{"green      ", 4'd5,  8'd0,   8'd128, 8'd0,   8'd255};
            5'd11:   e = '{"lime       ", 4'd4,  8'd0,   8'd255, 8'd0,   8'd255};
            5'd12:   e = '{"olive      ", 4'd5,  8'd128, 8'd128, 8'd0,   8'd255};
            5'd13:   e = '{"yellow     ", 4'd6,  8'd255, 8'd255, 8'd0,   8'd255};
            5'd14:   e = '{"navy       ", 4'd4,  8'd0,   8'd0,   8'd128, 8'd255};
            5'd15:   e = '{"blue       ", 4'd4,  8'd0,   8'd0,   8'd255, 8'd255};
            5'd16:   e = '{"teal       ", 4'd4,  8'd0,   8'd128, 8'd128, 8'd255};
            5'd17:   e = '{"aqua       ", 4'd4,  8'd0,   8'd255, 8'd255, 8'd255};
            5'd18:   e = '{"orange     ", 4'd6,  8'd255, 8'd165, 8'd0,   8'd255};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ccsp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccsp_parse
    import ccsp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_in  i_in,
    output logic      o_in_ready,
    output logic      o_res_valid,
    output t_res      o_res,
    input  wire logic i_res_ready
);

    logic                  r_in_valid;
    t_in                   r_in;
    t_mode                 r_mode, n_mode;
    logic [3:0]            r_count, n_count;
    logic [NAME_COUNT-1:0] r_cand, n_cand;
    logic [3:0]            r_stage, n_stage;
    logic [7:0]            r_red, n_red;
    logic [7:0]            r_green, n_green;
    logic [7:0]            r_blue, n_blue;
    logic                  r_int_nz, n_int_nz;
    logic [9:0]            r_frac, n_frac;
    logic [1:0]            r_frac_digits, n_frac_digits;
    logic                  r_alpha_seen, n_alpha_seen;
    logic                  r_hex_bad, n_hex_bad;
    logic                  r_res_valid;
    t_res                  r_res, n_res;

    logic res_free;
    logic step;

    // handshake: a non-final character never waits on the result side
    assign res_free    = !r_res_valid || i_res_ready;
    assign step        = r_in_valid && (!r_in.last_char || res_free);
    assign o_in_ready  = !r_in_valid || step;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // parse state, back to start after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (step && r_in.last_char)) begin
            r_mode        <= MODE_START;
            r_count       <= '0;
            r_cand        <= '1;
            r_stage       <= STG_AFTER_R;
            r_red         <= '0;
            r_green       <= '0;
            r_blue        <= '0;
            r_int_nz      <= 1'b0;
            r_frac        <= '0;
            r_frac_digits <= '0;
            r_alpha_seen  <= 1'b0;
            r_hex_bad     <= 1'b0;
        end else if (step) begin
            r_mode        <= n_mode;
            r_count       <= n_count;
            r_cand        <= n_cand;
            r_stage       <= n_stage;
            r_red         <= n_red;
            r_green       <= n_green;
            r_blue        <= n_blue;
            r_int_nz      <= n_int_nz;
            r_frac        <= n_frac;
            r_frac_digits <= n_frac_digits;
            r_alpha_seen  <= n_alpha_seen;
            r_hex_bad     <= n_hex_bad;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_free) begin
            r_res_valid <= step && r_in.last_char;
        end
        if (step && r_in.last_char) begin
            r_res <= n_res;
        end
    end

    // next state for one character
    always_comb begin
        logic [7:0]              c;
        logic                    dig;
        logic [3:0]              d;
        logic                    hex_ok;
        logic [3:0]              hex_v;
        logic [3:0]              ofs;
        logic [1:0]              k;
        logic [1:0]              sub;
        logic [3:0]              base;
        logic [7:0]              acc_sel;
        logic [7:0]              acc_new;
        logic                    acc_wr;
        t_name                   ent;
        logic [8*NAME_MAX_LEN-1:0] txt;

        c       = r_in.char_code;
        dig     = c inside {[CH_0:CH_9]};
        d       = dig ? 4'(c - CH_0) : 4'd0;
        hex_ok  = 1'b1;
        hex_v   = d;
        ofs     = r_stage - STG_RED;
        k       = 2'd0;
        sub     = 2'd0;
        base    = STG_RED;
        acc_sel = r_red;
        acc_new = r_red;
        acc_wr  = 1'b0;
        ent     = '0;
        txt     = '0;

        n_mode        = r_mode;
        n_count       = (r_count == 4'hF) ? r_count : r_count + 4'd1;
        n_cand        = r_cand;
        n_stage       = r_stage;
        n_red         = r_red;
        n_green       = r_green;
        n_blue        = r_blue;
        n_int_nz      = r_int_nz;
        n_frac        = r_frac;
        n_frac_digits = r_frac_digits;
        n_alpha_seen  = r_alpha_seen;
        n_hex_bad     = r_hex_bad;

        // drop names that disagree at this position
        for (int i = 0; i < NAME_COUNT; i++) begin
            ent = name_entry(NAME_IDX_W'(i));
            txt = ent.text << {r_count, 3'b000};
            if (!(r_count < ent.len && txt[8*NAME_MAX_LEN-1 -: 8] == c)) begin
                n_cand[i] = 1'b0;
            end
        end

        // hex digit value
        if (c inside {[CH_LA:CH_LF]}) begin
            hex_v = 4'(c - CH_LA + 8'd10);
        end else if (c inside {[CH_UA:CH_UF]}) begin
            hex_v = 4'(c - CH_UA + 8'd10);
        end else if (!dig) begin
            hex_ok = 1'b0;
        end

        // component field of the rgb grammar
        if (ofs >= 4'd6) begin
            k = 2'd2;
        end else if (ofs >= 4'd3) begin
            k = 2'd1;
        end
        sub  = 2'(ofs - {1'b0, k, 1'b0} - {2'b00, k});
        base = STG_RED + {1'b0, k, 1'b0} + {2'b00, k};

        case (r_mode)
            MODE_START: begin
                if (c == CH_HASH) begin
                    n_mode = MODE_HEX;
                end else if (c == CH_LR) begin
                    n_mode  = MODE_RGB;
                    n_stage = STG_AFTER_R;
                end else begin
                    n_mode = MODE_NONE;
                end
            end
            MODE_HEX: begin
                if (r_count >= 4'd1 && r_count <= 4'd6) begin
                    k = 2'((r_count - 4'd1) >> 1);
                    case (k)
                        2'd0:    acc_sel = r_red;
                        2'd1:    acc_sel = r_green;
                        default: acc_sel = r_blue;
                    endcase
                    if (!hex_ok) begin
                        n_hex_bad = 1'b1;
                    end else begin
                        acc_wr  = 1'b1;
                        acc_new = r_count[0] ? {hex_v, 4'h0} : (acc_sel | {4'h0, hex_v});
                    end
                end
            end
            MODE_RGB: begin
                if (r_stage == STG_AFTER_R) begin
                    if (c == CH_LG) n_stage = STG_AFTER_G;
                    else n_mode = MODE_NONE;
                end else if (r_stage == STG_AFTER_G) begin
                    if (c == CH_LB) n_stage = STG_AFTER_B;
                    else n_mode = MODE_NONE;
                end else if (r_stage == STG_AFTER_B) begin
                    if (c == CH_LPAREN) n_stage = STG_RED;
                    else if (c != CH_SPACE) n_mode = MODE_NONE;
                end else if (r_stage <= STG_LAST_COMP) begin
                    case (k)
                        2'd0:    acc_sel = r_red;
                        2'd1:    acc_sel = r_green;
                        default: acc_sel = r_blue;
                    endcase
                    if (dig && sub < 2'd2) begin
                        acc_wr  = 1'b1;
                        acc_new = 8'(12'(acc_sel) * 12'd10 + 12'(d));
                        n_stage = base + 4'd1;
                    end else if (c == CH_SPACE) begin
                        if (sub != 2'd0) n_stage = base + 4'd2;
                    end else if (c == CH_COMMA && k < 2'd2) begin
                        n_stage = base + 4'd3;
                    end else if (c == CH_COMMA) begin
                        n_stage      = STG_ALPHA_OPEN;
                        n_alpha_seen = 1'b1;
                    end else if (c == CH_RPAREN && k == 2'd2) begin
                        n_mode = MODE_CLOSED;
                    end else begin
                        n_mode = MODE_NONE;
                    end
                end else begin
                    // alpha field
                    if (c == CH_SPACE) begin
                        if (r_stage != STG_ALPHA_OPEN) n_mode = MODE_ATRAIL;
                    end else if (c == CH_RPAREN) begin
                        n_mode = MODE_CLOSED;
                    end else if (dig) begin
                        if (r_stage <= STG_ALPHA_INT) begin
                            if (d != 4'd0) n_int_nz = 1'b1;
                            n_stage = STG_ALPHA_INT;
                        end else if (r_stage == STG_ALPHA_FRAC &&
                                     r_frac_digits < 2'(ALPHA_FRAC_DIGITS)) begin
                            n_frac        = 10'(14'(r_frac) * 14'd10 + 14'(d));
                            n_frac_digits = r_frac_digits + 2'd1;
                        end
                    end else if (c == CH_DOT) begin
                        if (r_stage <= STG_ALPHA_INT) n_stage = STG_ALPHA_FRAC;
                        else if (r_stage == STG_ALPHA_FRAC) n_stage = STG_ALPHA_DONE;
                    end else begin
                        n_mode = MODE_NONE;
                    end
                end
            end
            MODE_ATRAIL: begin
                if (c == CH_RPAREN) n_mode = MODE_CLOSED;
                else if (c != CH_SPACE) n_mode = MODE_NONE;
            end
            MODE_CLOSED: begin
                n_mode = MODE_NONE;
            end
            MODE_NONE: begin
                n_mode = MODE_NONE;
            end
            default: begin
                n_mode = MODE_NONE;
            end
        endcase

        // write back the selected component
        if (acc_wr) begin
            case (k)
                2'd0:    n_red   = acc_new;
                2'd1:    n_green = acc_new;
                default: n_blue  = acc_new;
            endcase
        end
    end

    // result for a final character
    always_comb begin
        logic  found;
        t_name ent;

        found = 1'b0;
        ent   = '0;

        n_res            = '0;
        n_res.alpha      = 8'hFF;
        n_res.form       = FORM_UNKNOWN;

        if (n_mode == MODE_CLOSED) begin
            n_res.red   = n_red;
            n_res.green = n_green;
            n_res.blue  = n_blue;
            n_res.form  = FORM_RGB;
            if (!n_alpha_seen || n_int_nz) begin
                n_res.alpha = 8'hFF;
            end else if (n_frac_digits == 2'd0) begin
                n_res.alpha = 8'h00;
            end else begin
                // bring the fraction to thousandths
                n_res.alpha_calc = 1'b1;
                case (n_frac_digits)
                    2'd1:    n_res.alpha_frac = 10'(14'(n_frac) * 14'd100);
                    2'd2:    n_res.alpha_frac = 10'(14'(n_frac) * 14'd10);
                    default: n_res.alpha_frac = n_frac;
                endcase
            end
        end else if (n_mode == MODE_HEX && n_count == HEX_LEN) begin
            if (n_hex_bad) begin
                n_res.form = FORM_BAD_HEX;
            end else begin
                n_res.red   = n_red;
                n_res.green = n_green;
                n_res.blue  = n_blue;
                n_res.form  = FORM_HEX;
            end
        end else begin
            // first surviving name whose length ends here
            for (int i = 0; i < NAME_COUNT; i++) begin
                ent = name_entry(NAME_IDX_W'(i));
                if (!found && n_cand[i] &&
                    {1'b0, ent.len} == {1'b0, r_count} + 5'd1) begin
                    found       = 1'b1;
                    n_res.red   = ent.red;
                    n_res.green = ent.green;
                    n_res.blue  = ent.blue;
                    n_res.alpha = ent.alpha;
                    n_res.form  = FORM_NAMED;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ccsp_alpha.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccsp_alpha
    import ccsp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_res_valid,
    input  wire t_res i_res,
    output logic      o_res_ready,
    output logic      o_out_valid,
    output t_out      o_out,
    input  wire logic i_out_ready
);

    localparam int Y_W    = 16;
    localparam int Z_W    = Y_W - ALPHA_PRE_SHIFT;
    localparam int PROD_W = Z_W + 13;

    logic             r_out_valid;
    t_out             r_out, n_out;
    logic [Y_W-1:0]   y;
    logic [Z_W-1:0]   z;
    logic [PROD_W-1:0] prod;
    logic [8:0]       q;
    logic [7:0]       scaled;

    assign o_res_ready = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // thousandths to 0..255: divide by 200 as shift then reciprocal of 25
    always_comb begin
        y      = Y_W'(i_res.alpha_frac) * Y_W'(ALPHA_SCALE) + Y_W'(ALPHA_BIAS);
        z      = y[Y_W-1:ALPHA_PRE_SHIFT];
        prod   = PROD_W'(z) * PROD_W'(ALPHA_RECIP);
        q      = prod[ALPHA_RECIP_SHIFT +: 9];
        scaled = q[8] ? 8'hFF : q[7:0];
    end

    // output fields
    always_comb begin
        n_out.red   = i_res.red;
        n_out.green = i_res.green;
        n_out.blue  = i_res.blue;
        n_out.alpha = i_res.alpha_calc ? scaled : i_res.alpha;
        n_out.form  = i_res.form;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_out_valid <= i_res_valid;
        end
        if (o_res_ready && i_res_valid) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/css_color_string_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Color string parser: takes one ASCII character per cycle and, on the
// character flagged last, gives one color (red, green, blue, alpha, form) for
// rgb(r,g,b[,a]), #rrggbb or one of 19 names, black otherwise. A new character
// is taken in every cycle while the output is free; with the output stalled,
// up to two finished colors are held and only a further last character waits.
// The last character passes the input register, the parse stage and the alpha
// scaling stage before its color appears. The parse state returns to the
// start of a string by itself after each last character. No clearing pass.

module css_color_string_parser
    import ccsp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_in  i_in,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_out      o_out,
    input  wire logic i_out_ready
);

    logic res_valid;
    logic res_ready;
    t_res res;

    // character parsing
    ccsp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_ready  (o_in_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // alpha scaling and output register
    ccsp_alpha u_alpha (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_ready (i_out_ready)
    );

    // black fallbacks are opaque black
    a_black_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.form == FORM_UNKNOWN || o_out.form == FORM_BAD_HEX)
        |-> o_out.red == 8'h00 && o_out.green == 8'h00 && o_out.blue == 8'h00 &&
            o_out.alpha == 8'hFF)
        else $error("fallback color is not opaque black");

    // hex colors are always opaque
    a_hex_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.form == FORM_HEX |-> o_out.alpha == 8'hFF)
        else $error("hex color with alpha below opaque");

    // only defined form codes leave the block
    a_form_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.form <= FORM_BAD_HEX)
        else $error("undefined form code on output");

endmodule

`default_nettype wire

// ===== bench/css_color_string_parser_test.sv =====
`timescale 1ns / 1ps

module css_color_string_parser_test;
    import ccsp_pkg::*;

    localparam int ITEM_TARGET  = 1850;
    localparam int IDLE_PCT     = 9;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 16;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic in_valid = 1'b0;
    t_in  in_data  = '0;
    logic in_ready;
    logic out_valid;
    t_out out_data;
    logic out_ready = 1'b0;

    css_color_string_parser u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in        (in_data),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_out       (out_data),
        .i_out_ready (out_ready)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // named colors in priority order, rgba packed high to low
    string color_names [NAME_COUNT] = '{
        "transparent", "black", "silver", "gray", "grey", "white", "maroon",
        "red", "purple", "fuchsia", "green", "lime", "olive", "yellow",
        "navy", "blue", "teal", "aqua", "orange"
    };
    logic [31:0] color_rgba [NAME_COUNT] = '{
        32'hFFFFFF00, 32'h000000FF, 32'hC0C0C0FF, 32'h808080FF, 32'h808080FF,
        32'hFFFFFFFF, 32'h800000FF, 32'hFF0000FF, 32'h800080FF, 32'hFF00FFFF,
        32'h008000FF, 32'h00FF00FF, 32'h808000FF, 32'hFFFF00FF, 32'h000080FF,
        32'h0000FFFF, 32'h008080FF, 32'h00FFFFFF, 32'hFFA500FF
    };

    t_in         pending_chars [$];
    t_out        expected_colors [$];
    byte unsigned word [$];

    int chars_total;
    int chars_sent;
    int colors_seen;
    int mismatches;
    int stall_cycles;
    int form_seen [5];

    // no idling on either side over this stretch of the run
    wire calm = (chars_sent >= 700) && (chars_sent < 1100);

    // parser state mirror
    t_mode                 mode;
    logic [3:0]            char_pos;
    logic [NAME_COUNT-1:0] name_live;
    logic [3:0]            rgb_pos;
    logic [7:0]            comp_acc [3];
    logic                  alpha_whole;
    logic [9:0]            alpha_frac;
    logic [1:0]            frac_digits;
    logic                  alpha_given;
    logic                  hex_error;

    task automatic clear_parser();
        mode        = MODE_START;
        char_pos    = '0;
        name_live   = '1;
        rgb_pos     = STG_AFTER_R;
        comp_acc[0] = '0;
        comp_acc[1] = '0;
        comp_acc[2] = '0;
        alpha_whole = 1'b0;
        alpha_frac  = '0;
        frac_digits = '0;
        alpha_given = 1'b0;
        hex_error   = 1'b0;
    endtask

    // advance the mirror by one character, queue a color on the last one
    task automatic parse_char(input t_in item);
        logic [7:0] c;
        logic       dig;
        int         p, d, hv, k, sub, base, pw, av;
        t_out       res;
        c   = item.char_code;
        p   = char_pos;
        dig = (c >= CH_0) && (c <= CH_9);
        d   = dig ? c - CH_0 : 0;
        if (dig)
            hv = d;
        else if (c >= CH_LA && c <= CH_LF)
            hv = c - CH_LA + 10;
        else if (c >= CH_UA && c <= CH_UF)
            hv = c - CH_UA + 10;
        else
            hv = -1;

        // drop names that disagree at this position
        for (int i = 0; i < NAME_COUNT; i++) begin
            if (p >= color_names[i].len() || color_names[i][p] != c)
                name_live[i] = 1'b0;
        end

        if (mode == MODE_START) begin
            if (c == CH_HASH) begin
                mode = MODE_HEX;
            end else if (c == CH_LR) begin
                mode    = MODE_RGB;
                rgb_pos = STG_AFTER_R;
            end else begin
                mode = MODE_NONE;
            end
        end else if (mode == MODE_HEX) begin
            if (p >= 1 && p <= 6) begin
                k = (p - 1) / 2;
                if (hv < 0)
                    hex_error = 1'b1;
                else if (p % 2 == 1)
                    comp_acc[k] = hv << 4;
                else
                    comp_acc[k] = comp_acc[k] | hv;
            end
        end else if (mode == MODE_RGB) begin
            if (rgb_pos == STG_AFTER_R) begin
                if (c == CH_LG) rgb_pos = STG_AFTER_G;
                else mode = MODE_NONE;
            end else if (rgb_pos == STG_AFTER_G) begin
                if (c == CH_LB) rgb_pos = STG_AFTER_B;
                else mode = MODE_NONE;
            end else if (rgb_pos == STG_AFTER_B) begin
                if (c == CH_LPAREN) rgb_pos = STG_RED;
                else if (c != CH_SPACE) mode = MODE_NONE;
            end else if (rgb_pos <= STG_LAST_COMP) begin
                // three positions per component: leading space, digits, trailing space
                k    = (rgb_pos - STG_RED) / 3;
                sub  = (rgb_pos - STG_RED) % 3;
                base = STG_RED + 3 * k;
                if (dig && sub < 2) begin
                    comp_acc[k] = comp_acc[k] * 10 + d;
                    rgb_pos     = base + 1;
                end else if (c == CH_SPACE) begin
                    if (sub != 0) rgb_pos = base + 2;
                end else if (c == CH_COMMA && k < 2) begin
                    rgb_pos = base + 3;
                end else if (c == CH_COMMA) begin
                    rgb_pos     = STG_ALPHA_OPEN;
                    alpha_given = 1'b1;
                end else if (c == CH_RPAREN && k == 2) begin
                    mode = MODE_CLOSED;
                end else begin
                    mode = MODE_NONE;
                end
            end else begin
                // alpha field
                if (c == CH_SPACE) begin
                    if (rgb_pos != STG_ALPHA_OPEN) mode = MODE_ATRAIL;
                end else if (c == CH_RPAREN) begin
                    mode = MODE_CLOSED;
                end else if (dig) begin
                    if (rgb_pos <= STG_ALPHA_INT) begin
                        if (d != 0) alpha_whole = 1'b1;
                        rgb_pos = STG_ALPHA_INT;
                    end else if (rgb_pos == STG_ALPHA_FRAC &&
                                 frac_digits < ALPHA_FRAC_DIGITS) begin
                        alpha_frac  = alpha_frac * 10 + d;
                        frac_digits = frac_digits + 1;
                    end
                end else if (c == CH_DOT) begin
                    if (rgb_pos <= STG_ALPHA_INT) rgb_pos = STG_ALPHA_FRAC;
                    else if (rgb_pos == STG_ALPHA_FRAC) rgb_pos = STG_ALPHA_DONE;
                end else begin
                    mode = MODE_NONE;
                end
            end
        end else if (mode == MODE_ATRAIL) begin
            if (c == CH_RPAREN) mode = MODE_CLOSED;
            else if (c != CH_SPACE) mode = MODE_NONE;
        end else if (mode == MODE_CLOSED) begin
            mode = MODE_NONE;
        end

        if (char_pos < 15) char_pos = char_pos + 1;

        if (item.last_char) begin
            res = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd255, form: FORM_UNKNOWN};
            if (mode == MODE_CLOSED) begin
                res.red   = comp_acc[0];
                res.green = comp_acc[1];
                res.blue  = comp_acc[2];
                res.form  = FORM_RGB;
                if (!alpha_given || alpha_whole) begin
                    res.alpha = 8'd255;
                end else if (frac_digits == 0) begin
                    res.alpha = 8'd0;
                end else begin
                    pw = (frac_digits == 1) ? 10 : (frac_digits == 2) ? 100 : 1000;
                    av = (alpha_frac * 510 + pw) / (2 * pw);
                    res.alpha = (av > 255) ? 8'd255 : av;
                end
            end else if (mode == MODE_HEX && char_pos == HEX_LEN) begin
                if (hex_error) begin
                    res.form = FORM_BAD_HEX;
                end else begin
                    res.red   = comp_acc[0];
                    res.green = comp_acc[1];
                    res.blue  = comp_acc[2];
                    res.form  = FORM_HEX;
                end
            end else begin
                for (int i = 0; i < NAME_COUNT; i++) begin
                    if (name_live[i] && color_names[i].len() == p + 1) begin
                        {res.red, res.green, res.blue, res.alpha} = color_rgba[i];
                        res.form = FORM_NAMED;
                    end
                end
            end
            expected_colors.push_back(res);
            clear_parser();
        end
    endtask

    // string building
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            word.push_back(s[i]);
    endtask

    task automatic add_spaces(input int most);
        repeat ($urandom_range(0, most)) word.push_back(CH_SPACE);
    endtask

    task automatic add_digits(input int fewest, input int most);
        repeat ($urandom_range(fewest, most)) word.push_back(CH_0 + $urandom_range(0, 9));
    endtask

    task automatic send_word();
        t_in item;
        for (int i = 0; i < word.size(); i++) begin
            item.char_code = word[i];
            item.last_char = (i == word.size() - 1);
            pending_chars.push_back(item);
        end
        chars_total += word.size();
        word.delete();
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_word();
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // input side: mirror each transfer, then offer the next character
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                parse_char(in_data);
                chars_sent++;
            end
            if (!in_valid || in_ready) begin
                if (pending_chars.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_chars.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: check each color transfer against the oldest expectation
    always @(posedge clk) begin : color_check
        t_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                colors_seen++;
                if (expected_colors.size() == 0) begin
                    report_mismatch($sformatf("color %0d arrived with none expected",
                                              colors_seen));
                end else begin
                    want = expected_colors.pop_front();
                    if (out_data.red !== want.red)
                        report_mismatch($sformatf("color %0d red got %0d expected %0d",
                                                  colors_seen, out_data.red, want.red));
                    if (out_data.green !== want.green)
                        report_mismatch($sformatf("color %0d green got %0d expected %0d",
                                                  colors_seen, out_data.green, want.green));
                    if (out_data.blue !== want.blue)
                        report_mismatch($sformatf("color %0d blue got %0d expected %0d",
                                                  colors_seen, out_data.blue, want.blue));
                    if (out_data.alpha !== want.alpha)
                        report_mismatch($sformatf("color %0d alpha got %0d expected %0d",
                                                  colors_seen, out_data.alpha, want.alpha));
                    if (out_data.form !== want.form)
                        report_mismatch($sformatf("color %0d form got %0d expected %0d",
                                                  colors_seen, out_data.form, want.form));
                end
                if (out_data.form <= FORM_BAD_HEX) form_seen[out_data.form]++;
            end
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int    kind, n, m;
        string grammar;
        byte unsigned ch;
        grammar = " 0123456789,.)";
        clear_parser();

        // directed strings
        send_text("transparent");
        send_text("orange");
        send_text("red");
        send_text("grey");
        send_text("#00ff7F");
        send_text("#FFFFFF");
        send_text("#12g456");
        send_text("#1234");
        send_text("rgb(255,0,128)");
        send_text("rgb( 300 , 1 ,2 , 0.5 )");
        send_text("rgb(,,)");
        send_text("rgb(1,2,3,)");
        send_text("rgb(1,2,3,1)");
        send_text("rgb(1,2,3,0.9999)");
        send_text("rgb(1,2,3,.5.7)");
        send_text("rgb(1,2,3,0.)");
        send_text("rgb(1,2,3, 0.5 x)");
        send_text("rgb(1,2,3)x");
        send_text("rgb (9,99,999)");
        send_text("rgb(1 2,3,4)");
        send_text("Red");
        send_text("transparentx");
        send_text("aaaaaaaaaaaaaaaaaaaa");
        word.push_back(8'hFF);
        word.push_back(8'h00);
        send_word();

        // random strings, mostly well formed
        while (chars_total < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                add_text("rgb");
                add_spaces(2);
                add_text("(");
                for (int j = 0; j < 3; j++) begin
                    add_spaces(2);
                    add_digits(0, 4);
                    add_spaces(1);
                    if (j < 2) add_text(",");
                end
                if ($urandom_range(0, 1) == 1) begin
                    add_text(",");
                    add_spaces(2);
                    if ($urandom_range(0, 3) == 0) add_digits(1, 1);
                    else if ($urandom_range(0, 1) == 1) add_text("0");
                    if ($urandom_range(0, 3) != 0) begin
                        add_text(".");
                        add_digits(0, 5);
                        if ($urandom_range(0, 7) == 0) begin
                            add_text(".");
                            add_digits(0, 2);
                        end
                    end
                    add_spaces(2);
                end
                add_text(")");
                if ($urandom_range(0, 9) == 0)
                    word[$urandom_range(0, word.size() - 1)] = $urandom_range(0, 255);
                if ($urandom_range(0, 19) == 0) add_text(" ");
            end else if (kind < 55) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 8) : 6;
                add_text("#");
                repeat (n) begin
                    m  = $urandom_range(0, 15);
                    ch = (m < 10) ? CH_0 + m
                                  : (($urandom_range(0, 1) == 1) ? CH_LA : CH_UA) + m - 10;
                    word.push_back(ch);
                end
                if ($urandom_range(0, 9) == 0)
                    word[$urandom_range(1, word.size() - 1)] = $urandom_range(0, 255);
            end else if (kind < 80) begin
                add_text(color_names[$urandom_range(0, NAME_COUNT - 1)]);
                m = $urandom_range(0, 9);
                if (m == 0)
                    word[$urandom_range(0, word.size() - 1)] = CH_LA + $urandom_range(0, 25);
                else if (m == 1)
                    ch = word.pop_back();
                else if (m == 2)
                    word.push_back(CH_LA + $urandom_range(0, 25));
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 18)) word.push_back($urandom_range(0, 255));
            end else begin
                // broken rgb bodies built from grammar characters
                add_text("rgb(");
                repeat ($urandom_range(0, 14))
                    word.push_back(grammar[$urandom_range(0, grammar.len() - 1)]);
            end
            send_word();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (chars_sent != chars_total) @(posedge clk);
        while (expected_colors.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d characters, checked %0d colors, %0d mismatches",
                 chars_sent, colors_seen, mismatches);
        $display("forms: named %0d, hex %0d, rgb %0d, unknown %0d, bad hex %0d",
                 form_seen[FORM_NAMED], form_seen[FORM_HEX], form_seen[FORM_RGB],
                 form_seen[FORM_UNKNOWN], form_seen[FORM_BAD_HEX]);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ccsp_pkg.sv
rtl/core/ccsp_parse.sv
rtl/core/ccsp_alpha.sv
rtl/core/css_color_string_parser.sv
bench/css_color_string_parser_test.sv
